// ===== src/itda_pkg.sv =====
// shared types and constants for the decimal ascii converter
`timescale 1ns / 1ps
`default_nettype none

package itda_pkg;

  localparam int unsigned MagW        = 32;
  localparam int unsigned NumDigits   = 10;
  localparam int unsigned DigitIdxW   = $clog2(NumDigits);
  localparam int unsigned BitsPerStep = 2;
  localparam int unsigned NumSteps    = MagW / BitsPerStep;
  localparam int unsigned StepW       = $clog2(NumSteps);

  typedef logic [NumDigits-1:0][3:0] bcd_t;
  typedef logic [MagW-1:0]           mag_t;

  localparam logic [1:0] SignNone  = 2'd0;
  localparam logic [1:0] SignMinus = 2'd1;
  localparam logic [1:0] SignPlus  = 2'd2;
  localparam logic [1:0] SignSpace = 2'd3;

  localparam logic [1:0] ModePlus  = 2'd1;
  localparam logic [1:0] ModeSpace = 2'd2;

  localparam logic       ActSigned = 1'b0;

  // ascii '0' is 6'b110000, so a digit code is the digit under a 2'b11 prefix
  localparam logic [1:0] AsciiDigitHi = 2'b11;

endpackage

`default_nettype wire

// ===== src/itda_dabble.sv =====
// shift-add-3 step unit: moves two magnitude bits into the bcd register
`timescale 1ns / 1ps
`default_nettype none

module itda_dabble (
  input  itda_pkg::bcd_t bcd_i,
  input  itda_pkg::mag_t mag_i,
  output itda_pkg::bcd_t bcd_o,
  output itda_pkg::mag_t mag_o
);

  itda_pkg::bcd_t                    bcd_v;
  itda_pkg::mag_t                    mag_v;
  logic [4*itda_pkg::NumDigits-1:0]  flat_v;

  always_comb begin
    bcd_v  = bcd_i;
    mag_v  = mag_i;
    flat_v = '0;
    for (int s = 0; s < itda_pkg::BitsPerStep; s++) begin
      for (int d = 0; d < itda_pkg::NumDigits; d++) begin
        if (bcd_v[d] >= 4'd5) begin
          bcd_v[d] = bcd_v[d] + 4'd3;
        end
      end
      flat_v = bcd_v;
      bcd_v  = {flat_v[4*itda_pkg::NumDigits-2:0], mag_v[itda_pkg::MagW-1]};
      mag_v  = {mag_v[itda_pkg::MagW-2:0], 1'b0};
    end
    bcd_o = bcd_v;
    mag_o = mag_v;
  end

endmodule

`default_nettype wire

// ===== src/integer_to_decimal_ascii_top.sv =====
// decimal ascii converter top: sequencer around the shift-add-3 step unit
// sequence: accept, conversion at 2 bits per cycle, scan for the top digit, then
// one digit word per cycle while the output is not stalled, 1 to 10 words per value
// the next value is accepted only after the last digit word of this one is issued
// reset (rst_ni low, asynchronous) returns the sequencer to idle, no word pending
`timescale 1ns / 1ps
`default_nettype none

module integer_to_decimal_ascii_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [31:0] value_i,
  input  wire         action_i,
  input  wire  [1:0]  sign_mode_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [5:0]  digit_char_o,
  output logic        last_digit_o,
  output logic [1:0]  sign_code_o,
  output logic        was_zero_o
);

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StScan,
    StEmit
  } state_e;

  state_e                            state_q;
  itda_pkg::bcd_t                    bcd_q;
  itda_pkg::mag_t                    mag_q;
  logic [itda_pkg::StepW-1:0]        step_q;
  logic [itda_pkg::DigitIdxW-1:0]    idx_q;
  logic [1:0]                        sign_q;
  logic                              zero_q;

  itda_pkg::bcd_t                    bcd_step;
  itda_pkg::mag_t                    mag_step;
  logic [itda_pkg::DigitIdxW-1:0]    top_idx;
  logic                              in_fire;
  logic                              slot_free;
  logic [1:0]                        sign_d;
  itda_pkg::mag_t                    mag_d;

  itda_dabble u_dabble (
    .bcd_i (bcd_q),
    .mag_i (mag_q),
    .bcd_o (bcd_step),
    .mag_o (mag_step)
  );

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_o || out_ready_i;

  // sign and magnitude of the incoming word
  always_comb begin
    sign_d = itda_pkg::SignNone;
    mag_d  = value_i;
    if (action_i == itda_pkg::ActSigned) begin
      if (value_i[31]) begin
        sign_d = itda_pkg::SignMinus;
        mag_d  = ~value_i + 32'd1;
      end else if (sign_mode_i == itda_pkg::ModePlus) begin
        sign_d = itda_pkg::SignPlus;
      end else if (sign_mode_i == itda_pkg::ModeSpace) begin
        sign_d = itda_pkg::SignSpace;
      end
    end
  end

  // highest nonzero digit, zero value leaves index 0
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < itda_pkg::NumDigits; d++) begin
      if (bcd_q[d] != 4'd0) begin
        top_idx = itda_pkg::DigitIdxW'(d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      bcd_q        <= '0;
      mag_q        <= '0;
      step_q       <= '0;
      idx_q        <= '0;
      sign_q       <= itda_pkg::SignNone;
      zero_q       <= 1'b0;
      out_valid_o  <= 1'b0;
      digit_char_o <= '0;
      last_digit_o <= 1'b0;
      sign_code_o  <= itda_pkg::SignNone;
      was_zero_o   <= 1'b0;
    end else begin
      // in emit the pending word is replaced there, elsewhere it just drains
      if (out_valid_o && out_ready_i && (state_q != StEmit)) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            mag_q   <= mag_d;
            bcd_q   <= '0;
            step_q  <= '0;
            sign_q  <= sign_d;
            zero_q  <= (value_i == 32'd0);
            state_q <= StConv;
          end
        end
        StConv: begin
          bcd_q  <= bcd_step;
          mag_q  <= mag_step;
          step_q <= step_q + itda_pkg::StepW'(1);
          if (step_q == itda_pkg::StepW'(itda_pkg::NumSteps - 1)) begin
            state_q <= StScan;
          end
        end
        StScan: begin
          idx_q   <= top_idx;
          state_q <= StEmit;
        end
        StEmit: begin
          if (slot_free) begin
            out_valid_o  <= 1'b1;
            digit_char_o <= {itda_pkg::AsciiDigitHi, bcd_q[idx_q]};
            last_digit_o <= (idx_q == '0);
            sign_code_o  <= sign_q;
            was_zero_o   <= zero_q;
            if (idx_q == '0) begin
              state_q <= StIdle;
            end else begin
              idx_q <= idx_q - itda_pkg::DigitIdxW'(1);
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
